// ----- src/kdrq_pkg.sv -----
// ----------------------------------------------------------------------------
// kdrq_pkg: shared definitions of the keyed deadline request queue
// Field widths, command codes, the table entry layout and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kdrq_pkg;

  // default configuration
  localparam int MaxPendingDef      = 16;
  localparam int KindCountDef       = 8;
  localparam int ResolutionCountDef = 3;

  // field widths
  localparam int CmdW     = 3;
  localparam int OriginW  = 32;
  localparam int KindW    = 4;
  localparam int TimeW    = 64;
  localparam int ResW     = 3;
  localparam int RemovedW = 5;

  // saturation value of the removed count
  localparam logic [RemovedW-1:0] RemovedMax = 5'd31;

  // command codes
  localparam logic [CmdW-1:0] CMD_ENQUEUE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_RESOLVE  = 3'd1;
  localparam logic [CmdW-1:0] CMD_CANCEL   = 3'd2;
  localparam logic [CmdW-1:0] CMD_EXPIRE   = 3'd3;
  localparam logic [CmdW-1:0] CMD_SHUTDOWN = 3'd4;

  // one table entry
  typedef struct packed {
    logic [OriginW-1:0] origin;
    logic [KindW-1:0]   kind;
    logic [TimeW-1:0]   deadline;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture an accepted request
    logic step;    // advance the table walk
    logic finish;  // commit the operation and load the result register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_more;  // entries left to read
    logic out_full;   // result register still holds an untaken result
  } dp_status_t;

endpackage

`default_nettype wire

// ----- src/kdrq_if.sv -----
// ----------------------------------------------------------------------------
// kdrq_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface kdrq_req_if;
  logic                         valid;
  logic                         ready;
  logic [kdrq_pkg::CmdW-1:0]    cmd;
  logic [kdrq_pkg::OriginW-1:0] origin_id;
  logic [kdrq_pkg::KindW-1:0]   kind;
  logic [kdrq_pkg::TimeW-1:0]   now;
  logic [kdrq_pkg::TimeW-1:0]   deadline;
  logic [kdrq_pkg::ResW-1:0]    resolution;

  modport source (output valid, cmd, origin_id, kind, now, deadline, resolution,
                  input ready);
  modport sink   (input valid, cmd, origin_id, kind, now, deadline, resolution,
                  output ready);
endinterface

interface kdrq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic                          error_code;
  logic [kdrq_pkg::RemovedW-1:0] removed_count;

  modport source (output valid, ok, error_code, removed_count, input ready);
  modport sink   (input valid, ok, error_code, removed_count, output ready);
endinterface

`default_nettype wire

// ----- src/kdrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// kdrq_ctrl: operation sequencer
// Accepts a request, runs the table walk and commits once the result
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module kdrq_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  kdrq_pkg::dp_status_t status_i,
  output kdrq_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        // last read data is evaluated in this same cycle
        if (!status_i.scan_more) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!status_i.out_full) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/kdrq_dp.sv -----
// ----------------------------------------------------------------------------
// kdrq_dp: table storage and operation datapath
// Entry memory with one read and one write port, a compacting walk that
// drops entries in place, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kdrq_dp #(
  parameter int MAX_PENDING      = kdrq_pkg::MaxPendingDef,
  parameter int KIND_COUNT       = kdrq_pkg::KindCountDef,
  parameter int RESOLUTION_COUNT = kdrq_pkg::ResolutionCountDef
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  kdrq_pkg::ctrl_cmd_t                 ctrl_i,
  output kdrq_pkg::dp_status_t                status_o,
  input  wire  [kdrq_pkg::CmdW-1:0]           cmd_i,
  input  wire  [kdrq_pkg::OriginW-1:0]        origin_id_i,
  input  wire  [kdrq_pkg::KindW-1:0]          kind_i,
  input  wire  [kdrq_pkg::TimeW-1:0]          now_i,
  input  wire  [kdrq_pkg::TimeW-1:0]          deadline_i,
  input  wire  [kdrq_pkg::ResW-1:0]           resolution_i,
  input  wire                                 out_ready_i,
  output logic                                out_valid_o,
  output logic                                ok_o,
  output logic                                error_code_o,
  output logic [kdrq_pkg::RemovedW-1:0]       removed_count_o
);

  localparam int IdxW  = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int CntW  = $clog2(MAX_PENDING + 1);
  localparam int SatW  = (CntW > kdrq_pkg::RemovedW) ? CntW : kdrq_pkg::RemovedW;
  localparam int KindCW = kdrq_pkg::KindW + 1;
  localparam int ResCW  = kdrq_pkg::ResW + 1;

  // entry memory
  kdrq_pkg::entry_t mem_q [MAX_PENDING];
  kdrq_pkg::entry_t rd_data_q;

  // captured request
  logic [kdrq_pkg::CmdW-1:0]    cmd_q;
  logic [kdrq_pkg::OriginW-1:0] org_q;
  logic [kdrq_pkg::KindW-1:0]   kind_q;
  logic [kdrq_pkg::TimeW-1:0]   now_q;
  logic [kdrq_pkg::TimeW-1:0]   dl_q;
  logic [kdrq_pkg::ResW-1:0]    res_q;

  // walk state
  logic [CntW-1:0] rd_idx_q, wr_idx_q, rm_cnt_q, count_q;
  logic            ev_vld_q, ev_first_q, found_q, active_q;

  // result register
  logic                          out_vld_q;
  logic                          ok_q, err_q;
  logic [kdrq_pkg::RemovedW-1:0] rm_out_q;

  logic                          scan_more, kind_ok, res_ok, dl_passed;
  logic                          ev_expired, ev_match, drop, enq_ok;
  logic                          fin_ok, fin_err;
  logic [kdrq_pkg::RemovedW-1:0] fin_rm, rm_sat;
  logic [SatW-1:0]               rm_wide;
  logic                          mem_we;
  logic [IdxW-1:0]               mem_waddr;
  kdrq_pkg::entry_t              mem_wdata, new_entry;

  assign scan_more  = rd_idx_q < count_q;
  assign kind_ok    = {1'b0, kind_q} < KindCW'(KIND_COUNT);
  assign res_ok     = {1'b0, res_q} < ResCW'(RESOLUTION_COUNT);
  assign dl_passed  = (dl_q != '0) && (dl_q <= now_q);
  assign ev_expired = (rd_data_q.deadline != '0) && (rd_data_q.deadline <= now_q);
  assign ev_match   = (rd_data_q.origin == org_q) && (rd_data_q.kind == kind_q);

  assign enq_ok = active_q && (org_q != '0) && kind_ok && !dl_passed && !found_q &&
                  (count_q < CntW'(MAX_PENDING));

  // which walked entry leaves the table
  always_comb begin
    case (cmd_q)
      kdrq_pkg::CMD_RESOLVE: drop = active_q && res_ok && ev_first_q;
      kdrq_pkg::CMD_CANCEL:  drop = active_q && !found_q && ev_match;
      kdrq_pkg::CMD_EXPIRE:  drop = active_q && ev_expired;
      default:               drop = 1'b0;
    endcase
  end

  assign rm_wide = SatW'(rm_cnt_q);
  assign rm_sat  = (rm_wide > SatW'(kdrq_pkg::RemovedMax)) ? kdrq_pkg::RemovedMax
                                                           : rm_wide[kdrq_pkg::RemovedW-1:0];

  always_comb begin
    fin_ok  = 1'b0;
    fin_err = 1'b0;
    fin_rm  = '0;
    case (cmd_q)
      kdrq_pkg::CMD_ENQUEUE: begin
        fin_ok  = enq_ok;
        fin_err = !enq_ok;
      end
      kdrq_pkg::CMD_RESOLVE:  fin_ok = rm_cnt_q != '0;
      kdrq_pkg::CMD_CANCEL:   fin_ok = rm_cnt_q != '0;
      kdrq_pkg::CMD_EXPIRE: begin
        fin_ok = active_q;
        fin_rm = rm_sat;
      end
      kdrq_pkg::CMD_SHUTDOWN: fin_ok = 1'b1;
      default: begin
        fin_ok = 1'b0;
      end
    endcase
  end

  // write port: compaction during the walk, append at commit
  assign new_entry = '{origin: org_q, kind: kind_q, deadline: dl_q};
  always_comb begin
    if (ctrl_i.finish) begin
      mem_we    = (cmd_q == kdrq_pkg::CMD_ENQUEUE) && enq_ok;
      mem_waddr = count_q[IdxW-1:0];
      mem_wdata = new_entry;
    end else begin
      mem_we    = ctrl_i.step && ev_vld_q && !drop;
      mem_waddr = wr_idx_q[IdxW-1:0];
      mem_wdata = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && scan_more) begin
      rd_data_q <= mem_q[rd_idx_q[IdxW-1:0]];
    end
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q  <= cmd_i;
      org_q  <= origin_id_i;
      kind_q <= kind_i;
      now_q  <= now_i;
      dl_q   <= deadline_i;
      res_q  <= resolution_i;
    end
    if (ctrl_i.finish) begin
      ok_q     <= fin_ok;
      err_q    <= fin_err;
      rm_out_q <= fin_rm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      rm_cnt_q   <= '0;
      count_q    <= '0;
      ev_vld_q   <= 1'b0;
      ev_first_q <= 1'b0;
      found_q    <= 1'b0;
      active_q   <= 1'b1;
      out_vld_q  <= 1'b0;
    end else begin
      if (ctrl_i.load) begin
        rd_idx_q <= '0;
        wr_idx_q <= '0;
        rm_cnt_q <= '0;
        ev_vld_q <= 1'b0;
        found_q  <= 1'b0;
      end
      if (ctrl_i.step) begin
        ev_vld_q   <= scan_more;
        ev_first_q <= rd_idx_q == '0;
        if (scan_more) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
        if (ev_vld_q) begin
          if (drop) begin
            rm_cnt_q <= rm_cnt_q + 1'b1;
          end else begin
            wr_idx_q <= wr_idx_q + 1'b1;
          end
          if (ev_match) begin
            found_q <= 1'b1;
          end
        end
      end
      if (ctrl_i.finish) begin
        if (cmd_q == kdrq_pkg::CMD_SHUTDOWN) begin
          active_q <= 1'b0;
          count_q  <= '0;
        end else if (cmd_q == kdrq_pkg::CMD_ENQUEUE && enq_ok) begin
          count_q <= count_q + 1'b1;
        end else begin
          count_q <= count_q - rm_cnt_q;
        end
      end
      if (ctrl_i.finish) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign status_o.scan_more = scan_more;
  assign status_o.out_full  = out_vld_q;

  assign out_valid_o     = out_vld_q;
  assign ok_o            = ok_q;
  assign error_code_o    = err_q;
  assign removed_count_o = rm_out_q;

endmodule

`default_nettype wire

// ----- src/keyed_deadline_request_queue.sv -----
// ----------------------------------------------------------------------------
// keyed_deadline_request_queue: ordered pending-request table
// Requests keyed by (origin id, kind) with optional deadlines; enqueue,
// resolve oldest, cancel, expire and shutdown, one response per request.
// ----------------------------------------------------------------------------
//
//   channel  | dir | transfer when     | payload
//   ---------+-----+-------------------+----------------------------------------
//   req_i    | in  | valid && ready    | cmd, origin_id, kind, now, deadline,
//            |     |                   | resolution
//   rsp_o    | out | valid && ready    | ok, error_code, removed_count
//
// after transfer, a request walks the n pending entries (at most MAX_PENDING)
// of the single-read-port entry memory, one entry per cycle, compacting in
// place; the response sits in its own register, so a new request is taken
// while a response waits; a request finishes only once that register is free
// reset clears the table count, sets the block active and empties the
// response register; the entry memory itself is not cleared
//
`default_nettype none

module keyed_deadline_request_queue #(
  parameter int MAX_PENDING      = kdrq_pkg::MaxPendingDef,
  parameter int KIND_COUNT       = kdrq_pkg::KindCountDef,
  parameter int RESOLUTION_COUNT = kdrq_pkg::ResolutionCountDef
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  kdrq_req_if.sink    req_i,
  kdrq_rsp_if.source  rsp_o
);

  // control and status between sequencer and datapath
  kdrq_pkg::ctrl_cmd_t  ctrl_cmd;
  kdrq_pkg::dp_status_t dp_status;
  logic                 in_ready;

  assign req_i.ready = in_ready;

  // sequencer: idle, table walk, commit
  kdrq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // datapath: entry memory, walk counters, response register
  kdrq_dp #(
    .MAX_PENDING      (MAX_PENDING),
    .KIND_COUNT       (KIND_COUNT),
    .RESOLUTION_COUNT (RESOLUTION_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl_cmd),
    .status_o        (dp_status),
    .cmd_i           (req_i.cmd),
    .origin_id_i     (req_i.origin_id),
    .kind_i          (req_i.kind),
    .now_i           (req_i.now),
    .deadline_i      (req_i.deadline),
    .resolution_i    (req_i.resolution),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .ok_o            (rsp_o.ok),
    .error_code_o    (rsp_o.error_code),
    .removed_count_o (rsp_o.removed_count)
  );

endmodule

`default_nettype wire
